/* rtl/fm_write_shadow_mute_defines.svh */
// Assertion macros for the FM register-write shadow/mute block.
// Included by modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef FM_WRITE_SHADOW_MUTE_DEFINES_SVH
`define FM_WRITE_SHADOW_MUTE_DEFINES_SVH
`ifndef SYNTHESIS
`define FWSM_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fwsm assertion failed");
`define FWSM_ASSERT_NEXT(label, ante, cons) \
    `FWSM_ASSERT(label, (ante) |=> (cons))
`else
`define FWSM_ASSERT(label, prop)
`define FWSM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/fwsm_pkg.sv */
// Package for the FM register-write shadow/mute block: types, constants,
// microcode ROM, dispatch table and carrier slot mask table. No dependencies.
package fwsm_pkg;

    localparam int UPC_W = 5;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_MUTE   = 2'd1,
        OP_VOLUME = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        K_FETCH = 2'd0,
        K_MIX   = 2'd1,
        K_SLOT  = 2'd2
    } ukind_t;

    // one microcode control word
    typedef struct packed {
        ukind_t             kind;
        logic               item_src;   // channel/offset from the command, else mute run
        logic [2:0]         chan;
        logic [1:0]         slot;
        logic               last;
        logic [UPC_W-1:0]   next;
    } ucw_t;

    typedef struct packed {
        logic       accept;
        logic       advance;
        op_t        opcode;
    } seq_ctl_t;

    typedef struct packed {
        logic       emit;
        logic [8:0] addr;
        logic [7:0] data;
        logic       last;
    } wr_t;

    localparam logic [UPC_W-1:0] UPC_FETCH    = 5'd0;
    localparam logic [UPC_W-1:0] UPC_MIX      = 5'd1;
    localparam logic [UPC_W-1:0] UPC_MUTE_RUN = 5'd2;
    localparam logic [UPC_W-1:0] UPC_VOL_RUN  = 5'd26;
    localparam logic [UPC_W-1:0] UPC_END      = 5'd30;

    localparam logic [8:0] MIX_ADDR    = 9'h007;
    localparam logic [7:0] MUTE_MIX    = 8'h3F;
    localparam logic [6:0] LEVEL_MAX   = 7'h7F;
    localparam logic [7:0] MUTE_OFFSET = 8'h81;     // -127
    localparam logic [7:0] LEVEL_HI    = 8'h40;
    localparam logic [7:0] LEVEL_MASK  = 8'hF0;
    localparam logic [7:0] ALG_HI      = 8'hB0;
    localparam logic [7:0] ALG_MASK    = 8'hFC;

    function automatic logic [3:0] slot_mask(input logic [2:0] alg);
        logic [3:0] m;
        unique case (alg)
            3'd4:       m = 4'hC;
            3'd5, 3'd6: m = 4'hE;
            3'd7:       m = 4'hF;
            default:    m = 4'h8;
        endcase
        return m;
    endfunction

    function automatic logic [UPC_W-1:0] dispatch(input op_t op);
        logic [UPC_W-1:0] t;
        unique case (op)
            OP_MUTE:   t = UPC_MIX;
            OP_VOLUME: t = UPC_VOL_RUN;
            default:   t = UPC_FETCH;
        endcase
        return t;
    endfunction

    // Program: FETCH; MIX; mute run over channels 0,4,1,5,2,6 x slots 0..3;
    // volume run over slots 0..3 of the commanded channel.
    function automatic ucw_t ucode(input logic [UPC_W-1:0] upc);
        ucw_t             w;
        logic [UPC_W-1:0] midx;
        logic [UPC_W-1:0] vidx;
        midx = upc - UPC_MUTE_RUN;
        vidx = upc - UPC_VOL_RUN;
        w.kind     = K_FETCH;
        w.item_src = 1'b0;
        w.chan     = 3'd0;
        w.slot     = 2'd0;
        w.last     = 1'b0;
        w.next     = UPC_FETCH;
        priority if (upc == UPC_MIX)
        begin
            w.kind = K_MIX;
            w.next = UPC_MUTE_RUN;
        end
        else if (upc >= UPC_MUTE_RUN && upc < UPC_VOL_RUN)
        begin
            w.kind = K_SLOT;
            w.chan = {midx[2], midx[4:3]};
            w.slot = midx[1:0];
            w.last = (upc == UPC_VOL_RUN - 5'd1);
            w.next = w.last ? UPC_FETCH : upc + 5'd1;
        end
        else if (upc >= UPC_VOL_RUN && upc < UPC_END)
        begin
            w.kind     = K_SLOT;
            w.item_src = 1'b1;
            w.slot     = vidx[1:0];
            w.last     = (upc == UPC_END - 5'd1);
            w.next     = w.last ? UPC_FETCH : upc + 5'd1;
        end
        else
        begin
            w.kind = K_FETCH;
        end
        return w;
    endfunction

endpackage

/* rtl/fwsm_seq.sv */
// Microcode sequencer: step counter and control word lookup.
// Depends on fwsm_pkg.
module fwsm_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  fwsm_pkg::seq_ctl_t ctl,
    output fwsm_pkg::ucw_t   cw
);
    import fwsm_pkg::*;

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;

    assign cw = ucode(upc_reg);

    always_comb
    begin
        priority if (ctl.accept)
            upc_next = dispatch(ctl.opcode);
        else if (ctl.advance)
            upc_next = cw.next;
        else
            upc_next = upc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upc_reg <= UPC_FETCH;
        else
            upc_reg <= upc_next;
    end

endmodule

/* rtl/fwsm_dp.sv */
// Datapath: shadow registers, command latch, slot address and clamped level.
// Depends on fwsm_pkg.
module fwsm_dp (
    input  logic           clk,
    input  logic           rst_n,
    input  fwsm_pkg::ucw_t cw,
    input  logic           in_valid,
    input  logic           accept,
    input  fwsm_pkg::op_t  opcode,
    input  logic [8:0]     reg_addr,
    input  logic [7:0]     reg_data,
    input  logic           mute_on,
    input  logic [2:0]     channel,
    input  logic [7:0]     volume_offset,
    output fwsm_pkg::wr_t  wr
);
    import fwsm_pkg::*;

    logic [7:0] mix_sh_reg;
    logic [6:0] level_sh_reg [32];
    logic [2:0] alg_sh_reg [8];
    logic       mute_reg;
    logic [2:0] chan_reg;
    logic [7:0] off_reg;

    logic       shadow_wr;
    logic [2:0] ch;
    logic [7:0] off;
    logic [3:0] pos;
    logic [6:0] level;
    logic signed [9:0] diff;
    logic [6:0] clamped;
    logic [3:0] carriers;

    assign shadow_wr = accept && (opcode == OP_WRITE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_sh_reg   <= MUTE_MIX;
            level_sh_reg <= '{default: LEVEL_MAX};
            alg_sh_reg   <= '{default: 3'd0};
        end
        else if (shadow_wr)
        begin
            if (reg_addr == MIX_ADDR)
                mix_sh_reg <= reg_data;
            else if ((reg_addr[7:0] & LEVEL_MASK) == LEVEL_HI)
                level_sh_reg[{reg_addr[8], reg_addr[3:0]}] <= reg_data[6:0];
            else if ((reg_addr[7:0] & ALG_MASK) == ALG_HI)
                alg_sh_reg[{reg_addr[8], reg_addr[1:0]}] <= reg_data[2:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mute_reg <= mute_on;
            chan_reg <= channel;
            off_reg  <= volume_offset;
        end
    end

    assign ch  = cw.item_src ? chan_reg : cw.chan;
    assign off = cw.item_src ? off_reg : (mute_reg ? MUTE_OFFSET : 8'd0);
    assign pos = {cw.slot, ch[1:0]};
    assign level = level_sh_reg[{ch[2], pos}];
    assign diff = $signed({3'b000, level}) - $signed({{2{off[7]}}, off});
    assign carriers = slot_mask(alg_sh_reg[ch]);

    always_comb
    begin
        priority if (diff[9])
            clamped = 7'd0;
        else if (diff[8:7] != 2'b00)
            clamped = LEVEL_MAX;
        else
            clamped = diff[6:0];
    end

    always_comb
    begin
        unique case (cw.kind)
            K_FETCH:
            begin
                wr.emit = in_valid && (opcode == OP_WRITE);
                wr.addr = reg_addr;
                wr.data = reg_data;
                wr.last = 1'b1;
            end
            K_MIX:
            begin
                wr.emit = 1'b1;
                wr.addr = MIX_ADDR;
                wr.data = mute_reg ? MUTE_MIX : mix_sh_reg;
                wr.last = 1'b0;
            end
            K_SLOT:
            begin
                wr.emit = carriers[cw.slot];
                wr.addr = {ch[2], LEVEL_HI[7:4], pos};
                wr.data = {1'b0, clamped};
                wr.last = cw.last;
            end
            default:
            begin
                wr.emit = 1'b0;
                wr.addr = reg_addr;
                wr.data = reg_data;
                wr.last = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/fm_write_shadow_mute.sv */
// Top level of the FM register-write shadow/mute filter.
// Depends on fwsm_pkg, fwsm_seq, fwsm_dp and fm_write_shadow_mute_defines.svh.
//
// Usage: commands enter on the s_axis channel (tuser = opcode), chip writes
// leave on the m_axis channel, one transaction per write, tlast on the final
// write of each command.
// A register write is passed on and shadowed; it appears on m_axis the cycle
// after it is accepted, so writes stream at one per cycle while m_axis_tready is high.
// Mute/unmute runs 25 microcode steps (mix write plus 6 channels x 4 slots)
// and set-volume runs 4 steps; a step advances only when the output register
// is free, and slots that are not carriers of the channel's algorithm give
// no write. s_axis_tready is low while a program runs.
// Opcode 3 is consumed with no write.
// Reset clears the sequencer, the output valid flag and all shadows (mix 0x3F,
// levels 0x7F, algorithms 0). When m_axis_tready is low the single output
// register holds its write and the sequencer waits on the current step.
`include "fm_write_shadow_mute_defines.svh"
module fm_write_shadow_mute (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // reg_addr[8:0], reg_data[16:9], mute_on[17],
                                        // channel[20:18], volume_offset[28:21]
    input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_addr[8:0], out_data[16:9]
    output logic        m_axis_tlast
);
    import fwsm_pkg::*;

    ucw_t       cw;
    seq_ctl_t   ctl;
    wr_t        wr;
    op_t        opcode;
    logic       out_free;
    logic       accept;
    logic       out_load;

    logic       m_valid_reg;
    logic       m_valid_next;
    logic [8:0] m_addr_reg;
    logic [7:0] m_data_reg;
    logic       m_last_reg;

    assign opcode   = op_t'(s_axis_tuser);
    assign out_free = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (cw.kind == K_FETCH) && out_free;
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_load = wr.emit && out_free;

    assign ctl.accept  = accept;
    assign ctl.advance = (cw.kind != K_FETCH) && out_free;
    assign ctl.opcode  = opcode;

    fwsm_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .cw    (cw)
    );

    fwsm_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cw            (cw),
        .in_valid      (s_axis_tvalid),
        .accept        (accept),
        .opcode        (opcode),
        .reg_addr      (s_axis_tdata[8:0]),
        .reg_data      (s_axis_tdata[16:9]),
        .mute_on       (s_axis_tdata[17]),
        .channel       (s_axis_tdata[20:18]),
        .volume_offset (s_axis_tdata[28:21]),
        .wr            (wr)
    );

    always_comb
    begin
        priority if (out_load)
            m_valid_next = 1'b1;
        else if (m_axis_tready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_addr_reg <= wr.addr;
            m_data_reg <= wr.data;
            m_last_reg <= wr.last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'd0, m_data_reg, m_addr_reg};
    assign m_axis_tlast  = m_last_reg;

    `FWSM_ASSERT_NEXT(a_pass_through, accept && opcode == OP_WRITE, m_axis_tvalid && m_axis_tlast)
    `FWSM_ASSERT_NEXT(a_mute_starts_mix, accept && opcode == OP_MUTE, cw.kind == K_MIX)
    `FWSM_ASSERT(a_last_ends_program, (out_load && wr.last && cw.kind == K_SLOT) |-> (cw.next == UPC_FETCH))

endmodule
